>>> rtl/core/chp_pkg.sv
// Shared types, constants and a character class function for the cartridge header parser.
`default_nettype none

package chp_pkg;

   localparam int unsigned ADDR_W = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LOGO_LEN = 48;
   localparam int unsigned LOGO_IDX_W = $clog2(LOGO_LEN);

   localparam logic [ADDR_W-1:0] LOGO_FIRST  = 16'h0104;
   localparam logic [ADDR_W-1:0] LOGO_LAST   = 16'h0133;
   localparam logic [ADDR_W-1:0] TITLE_FIRST = 16'h0134;
   localparam logic [ADDR_W-1:0] TITLE_LAST  = 16'h0143;
   localparam logic [ADDR_W-1:0] ADDR_KIND   = 16'h0147;
   localparam logic [ADDR_W-1:0] ADDR_ROM    = 16'h0148;
   localparam logic [ADDR_W-1:0] ADDR_RAM    = 16'h0149;

   localparam logic [BYTE_W-1:0] CART_KIND_SMALL_RAM = 8'h06;
   localparam logic [BYTE_W-1:0] ROM_CODE_MAX        = 8'h08;

   localparam logic [BYTE_W-1:0] RAM_CODE_2K   = 8'h01;
   localparam logic [BYTE_W-1:0] RAM_CODE_8K   = 8'h02;
   localparam logic [BYTE_W-1:0] RAM_CODE_32K  = 8'h03;
   localparam logic [BYTE_W-1:0] RAM_CODE_128K = 8'h04;
   localparam logic [BYTE_W-1:0] RAM_CODE_64K  = 8'h05;

   localparam logic [15:0] RAM_END_NONE  = 16'h0000;
   localparam logic [15:0] RAM_END_SMALL = 16'hA1FF;
   localparam logic [15:0] RAM_END_2K    = 16'hA7FF;
   localparam logic [15:0] RAM_END_FULL  = 16'hBFFF;

   localparam logic [9:0] ROM_BANKS_SAT = 10'd512;

   localparam logic [BYTE_W-1:0] LOGO_TABLE [LOGO_LEN] = '{
      8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
      8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
      8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
      8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
      8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
      8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
   };

   typedef struct packed {
      logic [ADDR_W-1:0] byte_address;
      logic [BYTE_W-1:0] byte_value;
   } req_type;

   typedef struct packed {
      logic              title_char_valid;
      logic [3:0]        title_position;
      logic [BYTE_W-1:0] title_char;
      logic              logo_match;
      logic              logo_complete;
      logic [BYTE_W-1:0] cart_kind;
      logic [9:0]        rom_bank_count;
      logic              rom_code_unknown;
      logic [4:0]        ram_bank_count;
      logic [15:0]       ram_last_address;
   } rsp_type;

   function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
      logic digit;
      logic upper;
      logic lower;
      digit = (c >= 8'h30) && (c <= 8'h39);
      upper = (c >= 8'h41) && (c <= 8'h5A);
      lower = (c >= 8'h61) && (c <= 8'h7A);
      return digit || upper || lower;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/cartridge_header_parser_core.sv
// Cartridge header parser: logo check, title decode, size code latching and derivation.
//
// Usage:
//   req channel carries one header beat: a cartridge address and the byte read there.
//   rsp channel returns exactly one beat per req beat, in order.
//   Addresses 0x0104..0x0133 fold into the logo match flag (restart at 0x0104,
//   complete at 0x0133); 0x0134..0x0143 are decoded as title characters;
//   0x0147..0x0149 latch cartridge type, ROM size code and RAM size code.
//   Other addresses leave the state alone and still return a beat.
// Latency: the rsp beat is valid in the cycle after its req beat is accepted.
// Throughput: one beat per cycle while rsp_ready is high; decode, one table compare
//   and the size derivation all sit between the req port and the single rsp register.
// Reset: clears the rsp valid flag, sets the logo match flag, clears the logo
//   complete flag and the three latched header bytes.
// Stall: while rsp_valid is high and rsp_ready low the rsp beat holds and
//   req_ready drops; when rsp_ready is high a new req beat is taken in the same
//   cycle the pending rsp beat leaves.
`default_nettype none

module cartridge_header_parser_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire chp_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      chp_pkg::rsp_type rsp_data
);

   logic                  logo_ok_ff, logo_ok_in;
   logic                  logo_done_ff, logo_done_in;
   logic [7:0]            kind_ff, kind_in;
   logic [7:0]            rom_code_ff, rom_code_in;
   logic [7:0]            ram_code_ff, ram_code_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   chp_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  in_logo;
   logic                  in_title;
   logic                  logo_hit;
   logic [15:0]           logo_off;
   logic [15:0]           title_off;
   logic [chp_pkg::LOGO_IDX_W-1:0] logo_idx;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_logo  = (req_data.byte_address >= chp_pkg::LOGO_FIRST) &&
                     (req_data.byte_address <= chp_pkg::LOGO_LAST);
   assign in_title = (req_data.byte_address >= chp_pkg::TITLE_FIRST) &&
                     (req_data.byte_address <= chp_pkg::TITLE_LAST);
   assign logo_off  = req_data.byte_address - chp_pkg::LOGO_FIRST;
   assign title_off = req_data.byte_address - chp_pkg::TITLE_FIRST;
   assign logo_idx  = logo_off[chp_pkg::LOGO_IDX_W-1:0];
   assign logo_hit  = in_logo && (chp_pkg::LOGO_TABLE[logo_idx] == req_data.byte_value);

   always_comb begin
      logo_ok_in   = logo_ok_ff;
      logo_done_in = logo_done_ff;
      kind_in      = kind_ff;
      rom_code_in  = rom_code_ff;
      ram_code_in  = ram_code_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         if (in_logo) begin
            if (req_data.byte_address == chp_pkg::LOGO_FIRST) begin
               logo_ok_in   = logo_hit;
               logo_done_in = 1'b0;
            end else begin
               logo_ok_in = logo_ok_ff && logo_hit;
            end
            if (req_data.byte_address == chp_pkg::LOGO_LAST) begin
               logo_done_in = 1'b1;
            end
         end else if (req_data.byte_address == chp_pkg::ADDR_KIND) begin
            kind_in = req_data.byte_value;
         end else if (req_data.byte_address == chp_pkg::ADDR_ROM) begin
            rom_code_in = req_data.byte_value;
         end else if (req_data.byte_address == chp_pkg::ADDR_RAM) begin
            ram_code_in = req_data.byte_value;
         end

         rsp_valid_in                 = 1'b1;
         rsp_data_in.title_char_valid = in_title && chp_pkg::is_alnum(req_data.byte_value);
         rsp_data_in.title_position   = in_title ? title_off[3:0] : 4'd0;
         rsp_data_in.title_char       = in_title ? req_data.byte_value : 8'd0;
         rsp_data_in.logo_match       = logo_ok_in;
         rsp_data_in.logo_complete    = logo_done_in;
         rsp_data_in.cart_kind        = kind_in;

         rsp_data_in.rom_code_unknown = rom_code_in > chp_pkg::ROM_CODE_MAX;
         if (rom_code_in > chp_pkg::ROM_CODE_MAX) begin
            rsp_data_in.rom_bank_count = chp_pkg::ROM_BANKS_SAT;
         end else begin
            rsp_data_in.rom_bank_count = 10'(11'd2 << rom_code_in[3:0]);
         end

         rsp_data_in.ram_bank_count = (kind_in == chp_pkg::CART_KIND_SMALL_RAM) ? 5'd1 : 5'd0;
         case (ram_code_in)
            chp_pkg::RAM_CODE_8K:   rsp_data_in.ram_bank_count = 5'd1;
            chp_pkg::RAM_CODE_32K:  rsp_data_in.ram_bank_count = 5'd4;
            chp_pkg::RAM_CODE_128K: rsp_data_in.ram_bank_count = 5'd16;
            chp_pkg::RAM_CODE_64K:  rsp_data_in.ram_bank_count = 5'd8;
            default: ;
         endcase

         rsp_data_in.ram_last_address = chp_pkg::RAM_END_NONE;
         if (kind_in == chp_pkg::CART_KIND_SMALL_RAM) begin
            rsp_data_in.ram_last_address = chp_pkg::RAM_END_SMALL;
         end
         if (ram_code_in == chp_pkg::RAM_CODE_2K) begin
            rsp_data_in.ram_last_address = chp_pkg::RAM_END_2K;
         end
         if (ram_code_in > chp_pkg::RAM_CODE_2K) begin
            rsp_data_in.ram_last_address = chp_pkg::RAM_END_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         logo_ok_ff   <= 1'b1;
         logo_done_ff <= 1'b0;
         kind_ff      <= 8'd0;
         rom_code_ff  <= 8'd0;
         ram_code_ff  <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         logo_ok_ff   <= logo_ok_in;
         logo_done_ff <= logo_done_in;
         kind_ff      <= kind_in;
         rom_code_ff  <= rom_code_in;
         ram_code_ff  <= ram_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_reset_state: assert property (@(posedge clock)
      reset |=> (logo_ok_ff && !logo_done_ff && !rsp_valid_ff))
      else $error("state not cleared after reset");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted beat produced no rsp beat");

   a_logo_no_revive: assert property (@(posedge clock) disable iff (reset)
      (req_fire && in_logo && (req_data.byte_address != chp_pkg::LOGO_FIRST))
      |=> !(logo_ok_ff && !$past(logo_ok_ff)))
      else $error("logo match flag set without a restart");

   a_rom_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.rom_code_unknown)
      |-> (rsp_data_ff.rom_bank_count == chp_pkg::ROM_BANKS_SAT))
      else $error("unknown ROM code without saturated bank count");

   a_title_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.title_char_valid) |-> (rsp_data_ff.title_char != 8'd0))
      else $error("valid title character is zero");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench for the cartridge header parser core: directed and random header streams checked by a predictor.
`timescale 1ns / 1ps

class header_decode_tracker;
   logic             logo_ok;
   logic             logo_done;
   logic [7:0]       kind_byte;
   logic [7:0]       rom_code;
   logic [7:0]       ram_code;
   chp_pkg::rsp_type pending_decodes[$];
   int unsigned      mismatches;
   int unsigned      decodes_checked;
   int unsigned      logo_passes;
   int unsigned      valid_title_chars;

   function new();
      logo_ok = 1'b1;
      logo_done = 1'b0;
      kind_byte = '0;
      rom_code = '0;
      ram_code = '0;
      mismatches = 0;
      decodes_checked = 0;
      logo_passes = 0;
      valid_title_chars = 0;
   endfunction

   function void note_header_byte(chp_pkg::req_type beat);
      chp_pkg::rsp_type want;
      logic [15:0]      addr;
      logic [7:0]       val;
      logic             hit;
      want = '0;
      addr = beat.byte_address;
      val = beat.byte_value;
      if (addr >= chp_pkg::LOGO_FIRST && addr <= chp_pkg::LOGO_LAST) begin
         hit = (chp_pkg::LOGO_TABLE[int'(addr - chp_pkg::LOGO_FIRST)] == val);
         if (addr == chp_pkg::LOGO_FIRST) begin
            logo_ok = hit;
            logo_done = 1'b0;
         end else begin
            logo_ok = logo_ok & hit;
         end
         if (addr == chp_pkg::LOGO_LAST) logo_done = 1'b1;
      end else if (addr >= chp_pkg::TITLE_FIRST && addr <= chp_pkg::TITLE_LAST) begin
         want.title_position = 4'(addr - chp_pkg::TITLE_FIRST);
         want.title_char = val;
         want.title_char_valid = val inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
      end else if (addr == chp_pkg::ADDR_KIND) begin
         kind_byte = val;
      end else if (addr == chp_pkg::ADDR_ROM) begin
         rom_code = val;
      end else if (addr == chp_pkg::ADDR_RAM) begin
         ram_code = val;
      end
      want.logo_match = logo_ok;
      want.logo_complete = logo_done;
      want.cart_kind = kind_byte;
      want.rom_code_unknown = (rom_code > chp_pkg::ROM_CODE_MAX);
      if (rom_code == 8'd0) want.rom_bank_count = 10'd2;
      else if (rom_code > chp_pkg::ROM_CODE_MAX) want.rom_bank_count = chp_pkg::ROM_BANKS_SAT;
      else want.rom_bank_count = 10'(11'd2 << rom_code);
      want.ram_bank_count = (kind_byte == chp_pkg::CART_KIND_SMALL_RAM) ? 5'd1 : 5'd0;
      case (ram_code)
         chp_pkg::RAM_CODE_8K:   want.ram_bank_count = 5'd1;
         chp_pkg::RAM_CODE_32K:  want.ram_bank_count = 5'd4;
         chp_pkg::RAM_CODE_128K: want.ram_bank_count = 5'd16;
         chp_pkg::RAM_CODE_64K:  want.ram_bank_count = 5'd8;
         default: ;
      endcase
      want.ram_last_address = chp_pkg::RAM_END_NONE;
      if (kind_byte == chp_pkg::CART_KIND_SMALL_RAM)
         want.ram_last_address = chp_pkg::RAM_END_SMALL;
      if (ram_code == chp_pkg::RAM_CODE_2K) want.ram_last_address = chp_pkg::RAM_END_2K;
      if (ram_code > chp_pkg::RAM_CODE_2K) want.ram_last_address = chp_pkg::RAM_END_FULL;
      pending_decodes.push_back(want);
   endfunction

   function void report_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("beat %0d %s: expected 0x%0h got 0x%0h",
                     decodes_checked, field, want, got);
      end
   endfunction

   function void check_decode(chp_pkg::rsp_type got);
      chp_pkg::rsp_type want;
      if (pending_decodes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat: 0x%0h", got);
         return;
      end
      want = pending_decodes.pop_front();
      report_field("title_char_valid", want.title_char_valid, got.title_char_valid);
      report_field("title_position", want.title_position, got.title_position);
      report_field("title_char", want.title_char, got.title_char);
      report_field("logo_match", want.logo_match, got.logo_match);
      report_field("logo_complete", want.logo_complete, got.logo_complete);
      report_field("cart_kind", want.cart_kind, got.cart_kind);
      report_field("rom_bank_count", want.rom_bank_count, got.rom_bank_count);
      report_field("rom_code_unknown", want.rom_code_unknown, got.rom_code_unknown);
      report_field("ram_bank_count", want.ram_bank_count, got.ram_bank_count);
      report_field("ram_last_address", want.ram_last_address, got.ram_last_address);
      if (want.logo_complete && want.logo_match) logo_passes++;
      if (want.title_char_valid) valid_title_chars++;
      decodes_checked++;
   endfunction

   function int unsigned pending();
      return pending_decodes.size();
   endfunction
endclass

module testbench;
   localparam int unsigned HEADER_BEAT_TARGET = 850;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   chp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   chp_pkg::rsp_type rsp_data;

   header_decode_tracker tracker = new();

   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned beats_sent = 0;
   int unsigned header_beats = 0;
   int unsigned full_headers = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   int unsigned stall_phase = 0;

   cartridge_header_parser_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_pacer
      logic rdy;
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 120);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         0: rdy = 1'b1;
         1: rdy = 1'($urandom_range(0, 1));
         2: rdy = ($urandom_range(0, 3) == 0);
         default: rdy = (stall_phase[1:0] != 2'b11);
      endcase
      rsp_ready <= rdy;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_decode(rsp_data);
   end

   task automatic drive_header_byte(input logic [15:0] addr, input logic [7:0] val);
      int unsigned      gap;
      chp_pkg::req_type beat;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      beat.byte_address = addr;
      beat.byte_value = val;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      tracker.note_header_byte(beat);
      beats_sent++;
      if (addr >= chp_pkg::LOGO_FIRST && addr <= chp_pkg::ADDR_RAM) header_beats++;
   endtask

   task automatic drain_decodes();
      req_valid <= 1'b0;
      burst_left = 0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_title_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return 8'($urandom_range(8'h30, 8'h39));
         2: return 8'($urandom_range(8'h41, 8'h5A));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   function automatic logic [7:0] pick_logo_byte(int idx, bit corrupt);
      logic [7:0] v;
      v = chp_pkg::LOGO_TABLE[idx];
      if (corrupt) v = v ^ (8'h01 << $urandom_range(0, 7));
      return v;
   endfunction

   task automatic send_size_bytes();
      logic [7:0] kind_val;
      logic [7:0] rom_val;
      logic [7:0] ram_val;
      kind_val = ($urandom_range(0, 2) == 0) ? chp_pkg::CART_KIND_SMALL_RAM
                                             : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
         0: rom_val = 8'($urandom_range(9, 255));
         1: rom_val = 8'($urandom_range(9, 12));
         default: rom_val = 8'($urandom_range(0, 8));
      endcase
      ram_val = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 6));
      drive_header_byte(chp_pkg::ADDR_KIND, kind_val);
      drive_header_byte(chp_pkg::ADDR_ROM, rom_val);
      drive_header_byte(chp_pkg::ADDR_RAM, ram_val);
   endtask

   task automatic send_header();
      int         order [48];
      int         k;
      int         j;
      int         tmp;
      int         bad_idx;
      bit         scramble;
      bit         damaged;
      scramble = ($urandom_range(0, 4) == 0);
      damaged = ($urandom_range(0, 3) == 0);
      bad_idx = $urandom_range(0, 47);
      for (k = 0; k < 48; k++) order[k] = k;
      if (scramble) begin
         for (k = 47; k >= 2; k--) begin
            j = $urandom_range(1, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
         end
      end
      for (k = 0; k < 48; k++)
         drive_header_byte(chp_pkg::LOGO_FIRST + 16'(order[k]),
                           pick_logo_byte(order[k], damaged && order[k] == bad_idx));
      for (k = 0; k < 16; k++)
         drive_header_byte(chp_pkg::TITLE_FIRST + 16'(k), pick_title_char());
      for (k = 1; k <= 3; k++)
         if ($urandom_range(0, 1))
            drive_header_byte(chp_pkg::TITLE_LAST + 16'(k), 8'($urandom_range(0, 255)));
      send_size_bytes();
      full_headers++;
   endtask

   task automatic send_partial_logo();
      int count;
      int k;
      count = $urandom_range(1, 47);
      for (k = 0; k < count; k++)
         drive_header_byte(chp_pkg::LOGO_FIRST + 16'(k),
                           pick_logo_byte(k, $urandom_range(0, 30) == 0));
   endtask

   task automatic send_noise(input bit anywhere);
      int count;
      int k;
      count = $urandom_range(1, 6);
      for (k = 0; k < count; k++) begin
         if (anywhere) drive_header_byte(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
         else drive_header_byte(16'($urandom_range(16'h0100, 16'h014F)),
                                8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_directed();
      drive_header_byte(16'h0000, 8'h00);
      drive_header_byte(16'hFFFF, 8'hFF);
      drive_header_byte(chp_pkg::LOGO_FIRST, chp_pkg::LOGO_TABLE[0]);
      drive_header_byte(chp_pkg::LOGO_LAST, chp_pkg::LOGO_TABLE[47]);
      drive_header_byte(chp_pkg::LOGO_FIRST, 8'h00);
      drive_header_byte(chp_pkg::LOGO_FIRST + 16'd1, chp_pkg::LOGO_TABLE[1]);
      drive_header_byte(chp_pkg::LOGO_FIRST, chp_pkg::LOGO_TABLE[0]);
      drive_header_byte(16'h0120, ~chp_pkg::LOGO_TABLE[28]);
      drive_header_byte(chp_pkg::LOGO_LAST, chp_pkg::LOGO_TABLE[47]);
      drive_header_byte(16'h0103, 8'hCE);
      drive_header_byte(chp_pkg::TITLE_FIRST, 8'h2F);
      drive_header_byte(16'h0135, 8'h30);
      drive_header_byte(16'h0136, 8'h39);
      drive_header_byte(16'h0137, 8'h3A);
      drive_header_byte(16'h0138, 8'h40);
      drive_header_byte(16'h0139, 8'h41);
      drive_header_byte(16'h013A, 8'h5A);
      drive_header_byte(16'h013B, 8'h5B);
      drive_header_byte(16'h013D, 8'h61);
      drive_header_byte(16'h013E, 8'h7A);
      drive_header_byte(chp_pkg::TITLE_LAST, 8'h7B);
      drive_header_byte(16'h0144, 8'h41);
      drive_header_byte(chp_pkg::ADDR_KIND, chp_pkg::CART_KIND_SMALL_RAM);
      drive_header_byte(chp_pkg::ADDR_ROM, 8'hFF);
      drive_header_byte(chp_pkg::ADDR_RAM, chp_pkg::RAM_CODE_64K);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_directed();
      drain_decodes();
      while (header_beats < HEADER_BEAT_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_header();
            4: send_partial_logo();
            5, 6: send_size_bytes();
            7: drive_header_byte(chp_pkg::TITLE_FIRST + 16'($urandom_range(0, 15)),
                                 pick_title_char());
            8: send_noise(1'b0);
            default: send_noise(1'b1);
         endcase
         if ($urandom_range(0, 11) == 0) drain_decodes();
      end
      drain_decodes();
      repeat (4) @(posedge clock);
      $display("Sent %0d request beats (%0d in the header range, %0d full headers).",
               beats_sent, header_beats, full_headers);
      $display("Checked %0d result beats: %0d clean logo passes, %0d valid title chars.",
               tracker.decodes_checked, tracker.logo_passes, tracker.valid_title_chars);
      if (tracker.pending() != 0)
         $display("%0d results never arrived", tracker.pending());
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/chp_pkg.sv
rtl/core/cartridge_header_parser_core.sv
tb/testbench.sv
